// ===== rtl/vt_pkg.sv =====
// Package for the homogeneous vertex transform block.
// Holds widths, register indexes, the matrix type and the register reset values.
// Depends on nothing.
package vt_pkg;

   localparam int COORD_W       = 32;
   localparam int REG_W         = 64;
   localparam int NUM_REGS      = 8;
   localparam int ADDR_W        = $clog2(NUM_REGS) + 3;
   localparam int SUM_W         = 67;
   localparam int QUO_W         = 33;
   localparam int MAC_LAT       = 2;
   localparam int DIV_LAT       = QUO_W + 1;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic [COORD_W-1:0] MAX_POS = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] MIN_NEG = {1'b1, {(COORD_W-1){1'b0}}};

   localparam logic [2:0] REG_ROW0_COLS01 = 3'd0;
   localparam logic [2:0] REG_ROW0_COLS23 = 3'd1;
   localparam logic [2:0] REG_ROW1_COLS01 = 3'd2;
   localparam logic [2:0] REG_ROW1_COLS23 = 3'd3;
   localparam logic [2:0] REG_ROW2_COLS01 = 3'd4;
   localparam logic [2:0] REG_ROW2_COLS23 = 3'd5;
   localparam logic [2:0] REG_ROW3_COLS01 = 3'd6;
   localparam logic [2:0] REG_ROW3_COLS23 = 3'd7;

   typedef logic [NUM_REGS-1:0][REG_W-1:0] mat_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic wzero;
   } side_type;

   function automatic logic [REG_W-1:0] reset_value(input logic [2:0] idx, input int frac);
      logic [REG_W-1:0] one;
      logic [REG_W-1:0] res;
      one = REG_W'(1) << frac;
      case (idx)
         REG_ROW0_COLS01: res = one;
         REG_ROW1_COLS01: res = one << COORD_W;
         REG_ROW2_COLS23: res = one;
         REG_ROW3_COLS23: res = one << COORD_W;
         default:         res = '0;
      endcase
      return res;
   endfunction

endpackage

// ===== rtl/vt_csr.sv =====
// Matrix register file behind the APB-style configuration port.
// Depends on vt_pkg.
module vt_csr #(
   parameter int FRAC_BITS = vt_pkg::FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [vt_pkg::ADDR_W-1:0] paddr,
   input  logic [vt_pkg::REG_W-1:0]  pwdata,
   output logic [vt_pkg::REG_W-1:0]  prdata,
   output logic                      pready,
   output vt_pkg::mat_type           mat
);
   import vt_pkg::*;

   mat_type    regs_ff;
   logic [2:0] idx;
   logic       wr;

   assign idx    = paddr[ADDR_W-1:3];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = regs_ff[idx];
   assign mat    = regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= reset_value(3'(i), FRAC_BITS);
         end
      end else if (wr) begin
         regs_ff[idx] <= pwdata;
      end
   end

endmodule

// ===== rtl/vt_mac.sv =====
// Row-vector by matrix product: twelve registered products, then four registered column sums.
// Depends on vt_pkg.
module vt_mac #(
   parameter int FRAC_BITS = vt_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              adv,
   input  vt_pkg::mat_type                   mat,
   input  logic signed [vt_pkg::COORD_W-1:0] x,
   input  logic signed [vt_pkg::COORD_W-1:0] y,
   input  logic signed [vt_pkg::COORD_W-1:0] z,
   output logic signed [vt_pkg::SUM_W-1:0]   sum [4]
);
   import vt_pkg::*;

   logic signed [COORD_W-1:0]   ent [4][4];
   logic signed [COORD_W-1:0]   vec [3];
   logic signed [2*COORD_W-1:0] prod_ff [3][4];
   logic signed [2*COORD_W-1:0] prod_in [3][4];
   logic signed [SUM_W-1:0]     sum_ff [4];
   logic signed [SUM_W-1:0]     sum_in [4];

   assign vec[0] = x;
   assign vec[1] = y;
   assign vec[2] = z;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            ent[r][c] = mat[r*2 + c/2][(c%2)*COORD_W +: COORD_W];
         end
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 4; c++) begin
            prod_in[r][c] = vec[r] * ent[r][c];
         end
      end
      for (int c = 0; c < 4; c++) begin
         sum_in[c] = SUM_W'(prod_ff[0][c]) + SUM_W'(prod_ff[1][c]) + SUM_W'(prod_ff[2][c])
                   + (SUM_W'(ent[3][c]) <<< FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// ===== rtl/vt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with 32-bit saturation.
// Depends on vt_pkg.
module vt_div #(
   parameter int FRAC_BITS = vt_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              adv,
   input  logic signed [vt_pkg::SUM_W-1:0]   num,
   input  logic signed [vt_pkg::SUM_W-1:0]   den,
   output logic        [vt_pkg::COORD_W-1:0] quo,
   output logic                              sat
);
   import vt_pkg::*;

   localparam int MAG_W = SUM_W;
   localparam int CW    = MAG_W + QUO_W + FRAC_BITS + 1;

   logic [CW-1:0]    rem_ff [QUO_W+1];
   logic [CW-1:0]    rem_in [QUO_W+1];
   logic [QUO_W-1:0] q_ff   [QUO_W+1];
   logic [QUO_W-1:0] q_in   [QUO_W+1];
   logic [MAG_W-1:0] d_ff   [QUO_W+1];
   logic [MAG_W-1:0] d_in   [QUO_W+1];
   logic             neg_ff [QUO_W+1];
   logic             neg_in [QUO_W+1];
   logic             ps_ff  [QUO_W+1];
   logic             ps_in  [QUO_W+1];
   logic [MAG_W-1:0] nmag;
   logic [MAG_W-1:0] dmag;
   logic [CW-1:0]    t      [QUO_W+1];
   logic [QUO_W:0]   qmag;

   always_comb begin
      nmag      = num[SUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
      dmag      = den[SUM_W-1] ? MAG_W'(-den) : MAG_W'(den);
      rem_in[0] = CW'(nmag) << FRAC_BITS;
      q_in[0]   = '0;
      d_in[0]   = dmag;
      neg_in[0] = num[SUM_W-1] ^ den[SUM_W-1];
      ps_in[0]  = (CW'(nmag) << FRAC_BITS) >= (CW'(dmag) << QUO_W);
      t[0]      = '0;
      for (int k = 1; k <= QUO_W; k++) begin
         t[k]      = CW'(d_ff[k-1]) << (QUO_W - k);
         q_in[k]   = {q_ff[k-1][QUO_W-2:0], rem_ff[k-1] >= t[k]};
         rem_in[k] = (rem_ff[k-1] >= t[k]) ? rem_ff[k-1] - t[k] : rem_ff[k-1];
         d_in[k]   = d_ff[k-1];
         neg_in[k] = neg_ff[k-1];
         ps_in[k]  = ps_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
         d_ff   <= d_in;
         neg_ff <= neg_in;
         ps_ff  <= ps_in;
      end
   end

   always_comb begin
      qmag = ps_ff[QUO_W] ? {1'b1, {QUO_W{1'b0}}} : {1'b0, q_ff[QUO_W]};
      if (neg_ff[QUO_W]) begin
         sat = qmag > (QUO_W+1)'(MIN_NEG);
         quo = sat ? MIN_NEG : COORD_W'(-qmag);
      end else begin
         sat = qmag > (QUO_W+1)'(MAX_POS);
         quo = sat ? MAX_POS : qmag[COORD_W-1:0];
      end
   end

endmodule

// ===== rtl/homogeneous_vertex_transform.sv =====
// Top level of the homogeneous vertex transform: 4x4 matrix product with perspective divide.
// Depends on vt_pkg, vt_csr, vt_mac and vt_div.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_in_x, req_in_y, req_in_z, req_in_last
//   rsp      out        rsp_valid/rsp_stall  rsp_out_x/y/z, rsp_w_was_zero, rsp_saturated,
//                                            rsp_out_last
//   csr      in/out     psel/penable/pready  paddr, pwdata, prdata (64-bit, two matrix entries each)
//
// One vertex per cycle while no result is held by rsp_stall.
// Depth is set by the divider, which resolves one quotient bit per stage over 33 stages.
// The whole pipeline holds while a result waits on rsp_stall.
// Reset loads the identity matrix and empties the pipeline.
module homogeneous_vertex_transform #(
   parameter int FRAC_BITS = vt_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [vt_pkg::COORD_W-1:0] req_in_x,
   input  logic signed [vt_pkg::COORD_W-1:0] req_in_y,
   input  logic signed [vt_pkg::COORD_W-1:0] req_in_z,
   input  logic                              req_in_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [vt_pkg::COORD_W-1:0] rsp_out_x,
   output logic signed [vt_pkg::COORD_W-1:0] rsp_out_y,
   output logic signed [vt_pkg::COORD_W-1:0] rsp_out_z,
   output logic                              rsp_w_was_zero,
   output logic                              rsp_saturated,
   output logic                              rsp_out_last,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [vt_pkg::ADDR_W-1:0]         paddr,
   input  logic [vt_pkg::REG_W-1:0]          pwdata,
   output logic [vt_pkg::REG_W-1:0]          prdata,
   output logic                              pready
);
   import vt_pkg::*;

   localparam int PIPE = 1 + MAC_LAT + DIV_LAT;
   localparam int ZIDX = 1 + MAC_LAT;

   mat_type                   mat;
   logic                      adv;
   side_type                  side_ff [PIPE];
   side_type                  side_in [PIPE];
   logic signed [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic signed [SUM_W-1:0]   sum [4];
   logic        [COORD_W-1:0] quo [3];
   logic                      sat [3];
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]        ox_ff, oy_ff, oz_ff, ox_in, oy_in, oz_in;
   logic                      wz_ff, wz_in, sat_ff, sat_in, last_ff, last_in;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   vt_csr #(.FRAC_BITS(FRAC_BITS)) u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .mat
   );

   vt_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
      .clock, .adv, .mat, .x(x_ff), .y(y_ff), .z(z_ff), .sum
   );

   for (genvar g = 0; g < 3; g++) begin : g_div
      vt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock, .adv, .num(sum[g]), .den(sum[3]), .quo(quo[g]), .sat(sat[g])
      );
   end

   always_comb begin
      side_in[0] = '{valid: req_valid, last: req_in_last, wzero: 1'b0};
      for (int k = 1; k < PIPE; k++) begin
         side_in[k] = side_ff[k-1];
      end
      side_in[ZIDX].wzero = (sum[3] == '0);
   end

   always_comb begin
      rsp_valid_in = side_ff[PIPE-1].valid;
      last_in      = side_ff[PIPE-1].last;
      wz_in        = side_ff[PIPE-1].wzero;
      if (wz_in) begin
         ox_in  = '0;
         oy_in  = '0;
         oz_in  = '0;
         sat_in = 1'b0;
      end else begin
         ox_in  = quo[0];
         oy_in  = quo[1];
         oz_in  = quo[2];
         sat_in = sat[0] || sat[1] || sat[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE; k++) begin
            side_ff[k] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         side_ff      <= side_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff    <= req_in_x;
         y_ff    <= req_in_y;
         z_ff    <= req_in_z;
         ox_ff   <= ox_in;
         oy_ff   <= oy_in;
         oz_ff   <= oz_in;
         wz_ff   <= wz_in;
         sat_ff  <= sat_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = ox_ff;
   assign rsp_out_y      = oy_ff;
   assign rsp_out_z      = oz_ff;
   assign rsp_w_was_zero = wz_ff;
   assign rsp_saturated  = sat_ff;
   assign rsp_out_last   = last_ff;

endmodule

// ===== rtl/vt_check.sv =====
// Port-level checks for the homogeneous vertex transform, bound to the top level.
// Depends on vt_pkg and homogeneous_vertex_transform.
module vt_check (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [vt_pkg::COORD_W-1:0] rsp_out_x,
   input logic signed [vt_pkg::COORD_W-1:0] rsp_out_y,
   input logic signed [vt_pkg::COORD_W-1:0] rsp_out_z,
   input logic                              rsp_w_was_zero,
   input logic                              rsp_saturated
);
   import vt_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y)
                                 && $stable(rsp_out_z))
      else $error("stalled result word changed");

   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   a_wzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_w_was_zero |-> rsp_out_x == '0 && rsp_out_y == '0
                                      && rsp_out_z == '0 && !rsp_saturated)
      else $error("zero-w word carries nonzero data");

   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_out_x == MAX_POS || rsp_out_x == MIN_NEG || rsp_out_y == MAX_POS
         || rsp_out_y == MIN_NEG || rsp_out_z == MAX_POS || rsp_out_z == MIN_NEG)
      else $error("saturated word has no clamped coordinate");

endmodule

bind homogeneous_vertex_transform vt_check u_vt_check (.*);

// ===== tb/tb_homogeneous_vertex_transform.sv =====
// Testbench for homogeneous_vertex_transform: streams vertices through fixed and random matrices
// and compares each result word against a local fixed-point predictor.
// Depends on vt_pkg and the RTL of the block.
module tb_homogeneous_vertex_transform;
   timeunit 1ns;
   timeprecision 1ps;
   import vt_pkg::*;

   localparam int FRAC = FRAC_BITS_DEF;
   localparam int IDLE_LIMIT = 4000;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               last;
   } vertex_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               wzero;
      logic               sat;
      logic               last;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_in_x = '0, req_in_y = '0, req_in_z = '0;
   logic req_in_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_w_was_zero, rsp_saturated, rsp_out_last;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [REG_W-1:0] pwdata = '0;
   logic [REG_W-1:0] prdata;
   logic pready;

   homogeneous_vertex_transform #(.FRAC_BITS(FRAC)) dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   logic [REG_W-1:0] matrix [NUM_REGS];
   vertex_type pending_vertices [$];
   point_type  expected_points [$];
   int send_idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int idle_cycles = 0;

   function automatic logic signed [31:0] coeff(int r, int c);
      logic [63:0] reg_word;
      reg_word = matrix[r * 2 + c / 2];
      return (c % 2) ? reg_word[63:32] : reg_word[31:0];
   endfunction

   function automatic point_type transform_vertex(vertex_type v);
      logic signed [127:0] col [4];
      logic signed [127:0] num, quo;
      logic signed [31:0] res [3];
      point_type p;
      logic sat;
      sat = 1'b0;
      for (int c = 0; c < 4; c++) begin
         col[c] = (128'(signed'(coeff(3, c))) <<< FRAC)
                + 128'(signed'(v.x)) * 128'(signed'(coeff(0, c)))
                + 128'(signed'(v.y)) * 128'(signed'(coeff(1, c)))
                + 128'(signed'(v.z)) * 128'(signed'(coeff(2, c)));
      end
      for (int c = 0; c < 3; c++) begin
         res[c] = '0;
         if (col[3] != 0) begin
            num = col[c] <<< FRAC;
            quo = num / col[3];
            if (quo > 128'sd2147483647) begin
               res[c] = MAX_POS;
               sat = 1'b1;
            end else if (quo < -128'sd2147483648) begin
               res[c] = MIN_NEG;
               sat = 1'b1;
            end else begin
               res[c] = quo[31:0];
            end
         end
      end
      p.x = res[0];
      p.y = res[1];
      p.z = res[2];
      p.wzero = (col[3] == 0);
      p.sat = sat;
      p.last = v.last;
      return p;
   endfunction

   task automatic queue_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
      vertex_type v;
      v.x = x;
      v.y = y;
      v.z = z;
      v.last = last;
      pending_vertices.insert(pending_vertices.size(), v);
   endtask

   task automatic write_matrix(int idx, logic [63:0] value);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= ADDR_W'(idx * 8);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      matrix[idx] = value;
   endtask

   task automatic drain;
      while (pending_vertices.size() != 0 || expected_points.size() != 0) @(posedge clock);
      repeat (DIV_LAT + MAC_LAT + 8) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(signed'($urandom_range(0, 2 ** 21)) - 2 ** 20);
         3: return 32'(signed'($urandom_range(0, 2 ** 23)) - 2 ** 22);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_entry();
      case ($urandom_range(0, 5))
         0: return 32'h0001_0000;
         1: return 32'h0;
         2: return 32'(signed'($urandom_range(0, 2 ** 19)) - 2 ** 18);
         3: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (pending_vertices.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            vertex_type v;
            v = pending_vertices.pop_front();
            expected_points.insert(expected_points.size(), transform_vertex(v));
            req_valid <= 1'b1;
            req_in_x <= v.x;
            req_in_y <= v.y;
            req_in_z <= v.z;
            req_in_last <= v.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected result word x=%h", rsp_out_x);
            end else begin
               point_type e, a;
               e = expected_points.pop_front();
               a = {rsp_out_x, rsp_out_y, rsp_out_z, rsp_w_was_zero, rsp_saturated,
                    rsp_out_last};
               if (a !== e) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display({"mismatch: expected x=%h y=%h z=%h wz=%b sat=%b last=%b,",
                               " got x=%h y=%h z=%h wz=%b sat=%b last=%b"},
                        e.x, e.y, e.z, e.wzero, e.sat, e.last,
                        a.x, a.y, a.z, a.wzero, a.sat, a.last);
               end
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("homogeneous_vertex_transform test failed");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < NUM_REGS; i++) matrix[i] = reset_value(3'(i), FRAC);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // identity matrix after reset: field extremes
      queue_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b0);
      queue_vertex(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b1);
      queue_vertex(32'h0001_0000, 32'hfffe_0000, 32'h0000_8000, 1'b0);
      queue_vertex($urandom, $urandom, $urandom, 1'b1);
      drain();
      // zero w
      for (int i = 0; i < NUM_REGS; i++) write_matrix(i, '0);
      queue_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 1'b1);
      drain();
      // projection with negative w, overflow and truncation
      write_matrix(0, {32'h0, 32'h7fff_ffff});
      write_matrix(1, {32'hffff_0000, 32'h0});
      write_matrix(2, {32'h8000_0000, 32'h0});
      write_matrix(3, {32'h0000_0003, 32'h0});
      write_matrix(4, {32'h0, 32'h0});
      write_matrix(5, {32'h0, 32'h0001_0000});
      write_matrix(6, {32'h0, 32'h0});
      write_matrix(7, {32'h0000_0001, 32'h0});
      queue_vertex(32'h0001_0000, 32'h0, 32'h0, 1'b0);
      queue_vertex(32'hffff_0000, 32'h0, 32'h0, 1'b1);
      queue_vertex(32'h0, 32'h0001_0000, 32'h0, 1'b0);
      queue_vertex(32'h0, 32'h0000_0007, 32'h0000_0005, 1'b0);
      queue_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
      queue_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
      queue_vertex(32'h0, 32'hffff_fffb, 32'h0, 1'b0);
      drain();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 67; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 67; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
         endcase
         for (int i = 0; i < NUM_REGS; i++) begin
            if (phase == 7) write_matrix(i, 64'hffff_ffff_ffff_ffff);
            else if (phase == 6) write_matrix(i, {32'h8000_0000, 32'h7fff_ffff});
            else write_matrix(i, {rand_entry(), rand_entry()});
         end
         for (int n = 0; n < 100; n++) queue_vertex(rand_coord(), rand_coord(), rand_coord(),
                                                     1'($urandom));
         drain();
      end
      if (mismatches == 0) $display("homogeneous_vertex_transform test passed");
      else $display("homogeneous_vertex_transform test failed");
      $finish;
   end
endmodule
